### rtl/core/cwkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwkd_pkg
// Field widths and fixed constants of the k-distinct subarray counter.
// ----------------------------------------------------------------------------
package cwkd_pkg;

    localparam int VALUE_FIELD_BITS = 10;
    localparam int K_BITS           = 11;
    localparam int TOTAL_BITS       = 20;
    localparam int DIST_FIELD_BITS  = 11;
    localparam int S_TDATA_BITS     = 16;
    localparam int M_TDATA_BITS     = 32;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
    localparam logic [K_BITS-1:0]     K_RESET   = K_BITS'(1);

endpackage

### rtl/core/cwkd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwkd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cwkd_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word when both ports hit one address
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/count_windows_k_distinct_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// count_windows_k_distinct_unit
// Running count of subarrays with exactly k distinct values, sliding window.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one sequence element per item, value in s_tdata, end of the
//   sequence on s_tlast. m_ channel: one result per input item, the running
//   total and the distinct count of the window in m_tdata, the dropped flag
//   in m_tuser. k is written through cfg_wr_en / cfg_wr_data; the user
//   must write it only while idle, the block itself does not enforce this.
//   One small sequencer drives a frequency-table RAM and a sequence RAM,
//   both single read / single write with a registered read. Every element
//   that leaves the window edge costs one read-modify-write pass: pointer,
//   sequence read, count read, count write. Every element leaves once. An
//   item past MAX_LEN skips the window update and is flagged as dropped.
//   After an item with tlast, the counts of the elements from the near edge
//   up to the right index are zeroed one by one before s_tready returns.
//   After reset the frequency table is swept clean with s_tready low; k
//   returns to 1.
//   A finished result waits in the output register while m_tready is low;
//   the next item is still accepted and processed, and its result waits for
//   the register to empty.
// ----------------------------------------------------------------------------
module count_windows_k_distinct_unit #(
    parameter int VALUE_BITS = 10,
    parameter int MAX_LEN    = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration: k_distinct
    input  logic                                  cfg_wr_en,
    input  logic [cwkd_pkg::K_BITS-1:0]           cfg_wr_data,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [cwkd_pkg::S_TDATA_BITS-1:0]     s_tdata,   // [9:0] value, rest zero
    input  logic                                  s_tlast,   // last
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [cwkd_pkg::M_TDATA_BITS-1:0]     m_tdata,   // [19:0] running_total,
                                                             // [30:20] window_distinct
    output logic                                  m_tuser    // overflow
);

    localparam int TABLE_DEPTH = 1 << VALUE_BITS;
    localparam int AW          = $clog2(MAX_LEN);
    localparam int PW          = $clog2(MAX_LEN + 1);
    localparam int CW          = PW;
    localparam int CMPW        = (PW > cwkd_pkg::K_BITS) ? PW : cwkd_pkg::K_BITS;
    localparam int SUMW        = ((PW > cwkd_pkg::TOTAL_BITS) ? PW : cwkd_pkg::TOTAL_BITS) + 1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD,
        ST_LOOP,
        ST_SEQ,
        ST_CNT,
        ST_UPD,
        ST_FIN,
        ST_CLEAR
    } state_t;

    state_t                              state_reg, state_next;
    logic [cwkd_pkg::K_BITS-1:0]         k_reg, k_next;
    logic [PW-1:0]                       near_reg, near_next;
    logic [PW-1:0]                       far_reg, far_next;
    logic [PW-1:0]                       right_reg, right_next;
    logic [PW-1:0]                       dist_reg, dist_next;
    logic [cwkd_pkg::TOTAL_BITS-1:0]     total_reg, total_next;
    logic [VALUE_BITS-1:0]               val_reg, val_next;
    logic                                last_reg, last_next;
    logic                                drop_reg, drop_next;
    logic                                shrink_reg, shrink_next;
    logic                                pend_reg, pend_next;
    logic [VALUE_BITS-1:0]               init_cnt_reg, init_cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic [cwkd_pkg::TOTAL_BITS-1:0]     out_total_reg, out_total_next;
    logic [cwkd_pkg::DIST_FIELD_BITS-1:0] out_dist_reg, out_dist_next;
    logic                                out_drop_reg, out_drop_next;

    logic [VALUE_BITS-1:0]  in_value;
    logic                   seq_we, seq_re;
    logic [AW-1:0]          seq_waddr, seq_raddr;
    logic [VALUE_BITS-1:0]  seq_wdata, seq_rdata;
    logic                   cnt_we, cnt_re;
    logic [VALUE_BITS-1:0]  cnt_waddr, cnt_raddr;
    logic [CW-1:0]          cnt_wdata, cnt_rdata;

    logic [CMPW-1:0]        dist_ext, k_ext;
    logic [PW-1:0]          span;
    logic [SUMW-1:0]        sum;
    logic                   out_free;
    logic                   window_open;

    // the value field is cut to VALUE_BITS; when wider, to VALUE_FIELD_BITS and zero-extended
    if (VALUE_BITS <= cwkd_pkg::VALUE_FIELD_BITS) begin : g_val_narrow
        assign in_value = s_tdata[VALUE_BITS-1:0];
    end else begin : g_val_wide
        assign in_value = {{(VALUE_BITS - cwkd_pkg::VALUE_FIELD_BITS){1'b0}},
                           s_tdata[cwkd_pkg::VALUE_FIELD_BITS-1:0]};
    end

    cwkd_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_LEN)
    ) u_seq_ram (
        .aclk  (aclk),
        .we    (seq_we),
        .waddr (seq_waddr),
        .wdata (seq_wdata),
        .re    (seq_re),
        .raddr (seq_raddr),
        .rdata (seq_rdata)
    );

    cwkd_ram #(
        .WIDTH (CW),
        .DEPTH (TABLE_DEPTH)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign dist_ext    = CMPW'(dist_reg);
    assign k_ext       = CMPW'(k_reg);
    assign span        = near_reg - far_reg + PW'(1);
    assign sum         = SUMW'(total_reg) + SUMW'(span);
    assign out_free    = !out_valid_reg || m_tready;
    assign window_open = near_reg < right_reg;

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        near_next      = near_reg;
        far_next       = far_reg;
        right_next     = right_reg;
        dist_next      = dist_reg;
        total_next     = total_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        drop_next      = drop_reg;
        shrink_next    = shrink_reg;
        pend_next      = pend_reg;
        init_cnt_next  = init_cnt_reg;
        out_valid_next = out_valid_reg;
        out_total_next = out_total_reg;
        out_dist_next  = out_dist_reg;
        out_drop_next  = out_drop_reg;

        seq_we    = 1'b0;
        seq_waddr = right_reg[AW-1:0];
        seq_wdata = in_value;
        seq_re    = 1'b0;
        seq_raddr = near_reg[AW-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = val_reg;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = val_reg;

        if (cfg_wr_en) begin
            k_next = cfg_wr_data;
        end
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT: begin
                cnt_we        = 1'b1;
                cnt_waddr     = init_cnt_reg;
                init_cnt_next = init_cnt_reg + VALUE_BITS'(1);
                if (&init_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    val_next  = in_value;
                    last_next = s_tlast;
                    if (right_reg == PW'(MAX_LEN)) begin
                        drop_next  = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        drop_next  = 1'b0;
                        seq_we     = 1'b1;
                        cnt_re     = 1'b1;
                        cnt_raddr  = in_value;
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                cnt_we     = 1'b1;
                cnt_wdata  = cnt_rdata + CW'(1);
                right_next = right_reg + PW'(1);
                if (cnt_rdata == '0) begin
                    dist_next = dist_reg + PW'(1);
                end
                state_next = ST_LOOP;
            end
            ST_LOOP: begin
                // shrink while too many distinct values, then walk the near edge
                priority if (window_open && dist_ext > k_ext) begin
                    shrink_next = 1'b1;
                    state_next  = ST_SEQ;
                end else if (window_open) begin
                    shrink_next = 1'b0;
                    state_next  = ST_SEQ;
                end else begin
                    state_next  = ST_FIN;
                end
            end
            ST_SEQ: begin
                seq_re     = 1'b1;
                state_next = ST_CNT;
            end
            ST_CNT: begin
                val_next   = seq_rdata;
                cnt_re     = 1'b1;
                cnt_raddr  = seq_rdata;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                priority if (shrink_reg) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rdata - CW'(1);
                    if (cnt_rdata == CW'(1)) begin
                        dist_next = dist_reg - PW'(1);
                    end
                    near_next  = near_reg + PW'(1);
                    far_next   = near_reg + PW'(1);
                    state_next = ST_LOOP;
                end else if (cnt_rdata > CW'(1)) begin
                    cnt_we     = 1'b1;
                    cnt_wdata  = cnt_rdata - CW'(1);
                    near_next  = near_reg + PW'(1);
                    state_next = ST_LOOP;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_total_next = total_reg;
                    if (!drop_reg && k_reg != '0 && dist_ext == k_ext) begin
                        if (sum > SUMW'(cwkd_pkg::TOTAL_MAX)) begin
                            total_next     = cwkd_pkg::TOTAL_MAX;
                            out_total_next = cwkd_pkg::TOTAL_MAX;
                        end else begin
                            total_next     = sum[cwkd_pkg::TOTAL_BITS-1:0];
                            out_total_next = sum[cwkd_pkg::TOTAL_BITS-1:0];
                        end
                    end
                    out_dist_next = dist_ext[cwkd_pkg::DIST_FIELD_BITS-1:0];
                    out_drop_next = drop_reg;
                    pend_next     = 1'b0;
                    state_next    = last_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR: begin
                // only the entries from the near edge up hold nonzero counts: zero them in turn
                if (pend_reg) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = seq_rdata;
                end
                if (window_open) begin
                    seq_re    = 1'b1;
                    near_next = near_reg + PW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        near_next  = '0;
                        far_next   = '0;
                        right_next = '0;
                        dist_next  = '0;
                        total_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg       <= val_next;
        last_reg      <= last_next;
        drop_reg      <= drop_next;
        shrink_reg    <= shrink_next;
        out_total_reg <= out_total_next;
        out_dist_reg  <= out_dist_next;
        out_drop_reg  <= out_drop_next;
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            k_reg         <= cwkd_pkg::K_RESET;
            near_reg      <= '0;
            far_reg       <= '0;
            right_reg     <= '0;
            dist_reg      <= '0;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            near_reg      <= near_next;
            far_reg       <= far_next;
            right_reg     <= right_next;
            dist_reg      <= dist_next;
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            init_cnt_reg  <= init_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_dist_reg, out_total_reg};
    assign m_tuser  = out_drop_reg;

    // window pointers stay ordered
    a_far_le_near: assert property (@(posedge aclk) disable iff (!aresetn)
        far_reg <= near_reg)
        else $error("far edge passed near edge");

    a_near_le_right: assert property (@(posedge aclk) disable iff (!aresetn)
        near_reg <= right_reg)
        else $error("near edge passed right index");

    a_dist_le_right: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_reg <= right_reg)
        else $error("distinct count exceeds stored length");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item still in work");

    a_total_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_CLEAR |=> total_reg >= $past(total_reg))
        else $error("running total decreased outside end-of-sequence clear");

endmodule
